// File: design/assert_macros.svh
// assert_macros.svh - concurrent assertion helpers shared by the RTL.
// No dependencies; each user passes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// File: design/utcofs_pkg.sv
// utcofs_pkg - types, calendar constants and helpers for the UTC offset unit.
// No dependencies.
package utcofs_pkg;

    typedef logic [31:0]        t_utc;
    typedef logic signed [10:0] t_offset;
    typedef logic [1:0]         t_rule;
    typedef logic [1:0]         t_cfg_index;
    typedef logic [10:0]        t_cfg_data;
    typedef logic [8:0]         t_doy;
    typedef logic [16:0]        t_sod;
    typedef logic [2:0]         t_wday;

    // configuration register indexes
    localparam t_cfg_index CfgIdxBase = 2'd0;
    localparam t_cfg_index CfgIdxRule = 2'd1;

    // daylight saving rule codes
    localparam t_rule RuleNone = 2'd0;
    localparam t_rule RuleUs   = 2'd1;
    localparam t_rule RuleEu   = 2'd2;

    // days = (utc >> 7) / 675 by reciprocal
    localparam int unsigned DayPreShift   = 7;
    localparam int unsigned DayRecipMul   = 50903317;
    localparam int unsigned DayRecipShift = 35;
    localparam int unsigned SecsPerDay    = 86400;

    // day count from 1968-03-01; 2100-03-01 gets an extra day so that
    // every four-year cycle is 1461 days long
    localparam int unsigned EpochToMarch   = 671;
    localparam int unsigned CenturyFixDay  = 47541;
    localparam int unsigned CycleDays      = 1461;
    localparam int unsigned CycleRecipMul  = 91868;
    localparam int unsigned CycleRecipShft = 27;
    localparam int unsigned YearDays       = 365;

    // x % 7 by reciprocal
    localparam int unsigned WeekDays      = 7;
    localparam int unsigned ThursdayShift = 4;
    localparam int unsigned Mod7Mul16     = 74899;
    localparam int unsigned Mod7Shift16   = 19;
    localparam int unsigned Mod7Mul9      = 586;
    localparam int unsigned Mod7Shift9    = 12;

    // day-of-year counted from March 1
    localparam int unsigned MarLastDoy  = 30;
    localparam int unsigned OctLastDoy  = 244;
    localparam int unsigned NovFirstDoy = 245;

    localparam int unsigned UsStartSec = 25200;
    localparam int unsigned UsEndSec   = 21600;
    localparam int unsigned EuSwitchSec = 3600;

    localparam int DstShiftMin = 60;
    localparam int OffsetMax   = 1023;

    // reduce 0..13 to 0..6
    function automatic t_wday wrap7(logic [3:0] v);
        logic [3:0] t;
        t = (v >= 4'(WeekDays)) ? v - 4'(WeekDays) : v;
        return t[2:0];
    endfunction

endpackage

// File: design/utc_offset_with_dst_rules_unit.sv
// utc_offset_with_dst_rules_unit - eight-stage pipeline from UTC seconds to local offset.
// Depends on utcofs_pkg and assert_macros.svh.

// One timestamp may be started every clock cycle; busy stays low. Each result
// appears on o_offset_minutes/o_dst_active with a one-cycle o_valid strobe
// after the start transfer, in start order, and cannot be held off. The eight
// register stages are: day split by reciprocal multiply, seconds-of-day and
// weekday, four-year cycle, day within cycle, year within cycle, weekday of
// March 1, transition days, compare.
// Configuration transfers are always accepted (o_cfg_ready high); the registers
// are read in the last two stages, so write them only while no result is pending.
// Results are exact over the full 32-bit range, to 2106.
`include "assert_macros.svh"

module utc_offset_with_dst_rules_unit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  utcofs_pkg::t_utc        i_utc_seconds,
    output logic                    o_valid,
    output utcofs_pkg::t_offset     o_offset_minutes,
    output logic                    o_dst_active,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  utcofs_pkg::t_cfg_index  i_cfg_index,
    input  utcofs_pkg::t_cfg_data   i_cfg_data
);
    import utcofs_pkg::*;

    localparam int unsigned NumStages = 8;

    logic [NumStages:1] r_vld;
    t_offset            r_base;
    t_rule              r_rule;

    // stage 1
    logic [50:0] n_s1_prod;
    t_utc        r_s1_utc;
    logic [15:0] r_s1_days;
    // stage 2
    logic [32:0] n_s2_dsec;
    logic [15:0] n_s2_wkx;
    logic [32:0] n_s2_wprod;
    t_sod        r_s2_sod;
    logic [15:0] r_s2_mar;
    logic [15:0] r_s2_wkx;
    logic [13:0] r_s2_wq;
    // stage 3
    logic [32:0] n_s3_cprod;
    t_sod        r_s3_sod;
    logic [15:0] r_s3_mar;
    logic [5:0]  r_s3_cyc;
    t_wday       r_s3_wnow;
    // stage 4
    t_sod        r_s4_sod;
    logic [10:0] r_s4_rem;
    t_wday       r_s4_wnow;
    // stage 5
    t_doy        n_s5_doy;
    t_sod        r_s5_sod;
    t_doy        r_s5_doy;
    t_wday       r_s5_wnow;
    // stage 6
    logic [18:0] n_s6_dprod;
    logic [6:0]  n_s6_dq;
    t_wday       n_s6_dmod;
    t_sod        r_s6_sod;
    t_doy        r_s6_doy;
    t_wday       r_s6_w1;
    // stage 7
    t_wday       n_s7_fs;
    t_wday       n_s7_ma;
    t_wday       n_s7_ob;
    logic        n_s7_en;
    t_doy        n_s7_sd;
    t_doy        n_s7_ed;
    t_sod        n_s7_ss;
    t_sod        n_s7_es;
    t_sod        r_s7_sod;
    t_doy        r_s7_doy;
    logic        r_s7_en;
    t_doy        r_s7_sd;
    t_doy        r_s7_ed;
    t_sod        r_s7_ss;
    t_sod        r_s7_es;
    // stage 8
    logic              n_s8_ge;
    logic              n_s8_lt;
    logic              n_s8_dst;
    logic signed [11:0] n_s8_sum;
    t_offset           n_s8_off;
    t_offset           r_out_off;
    logic              r_out_dst;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_base <= '0;
            r_rule <= RuleNone;
        end else begin
            r_vld <= {r_vld[NumStages-1:1], start && !busy};
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CfgIdxBase: r_base <= t_offset'(i_cfg_data);
                    CfgIdxRule: r_rule <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_s1_prod = 51'(i_utc_seconds[31:DayPreShift]) * 51'(DayRecipMul);

        n_s2_dsec  = 33'(r_s1_days) * 33'(SecsPerDay);
        n_s2_wkx   = r_s1_days + 16'(ThursdayShift);
        n_s2_wprod = 33'(n_s2_wkx) * 33'(Mod7Mul16);

        n_s3_cprod = 33'(r_s2_mar) * 33'(CycleRecipMul);

        if (r_s4_rem >= 11'(3 * YearDays)) begin
            n_s5_doy = 9'(r_s4_rem - 11'(3 * YearDays));
        end else if (r_s4_rem >= 11'(2 * YearDays)) begin
            n_s5_doy = 9'(r_s4_rem - 11'(2 * YearDays));
        end else if (r_s4_rem >= 11'(YearDays)) begin
            n_s5_doy = 9'(r_s4_rem - 11'(YearDays));
        end else begin
            n_s5_doy = 9'(r_s4_rem);
        end

        n_s6_dprod = 19'(r_s5_doy) * 19'(Mod7Mul9);
        n_s6_dq    = n_s6_dprod[18:Mod7Shift9];
        n_s6_dmod  = 3'(r_s5_doy - 9'(n_s6_dq * 7'(WeekDays)));

        // Sunday offsets from March 1; Nov 1 shares the weekday of March 1
        n_s7_fs = (r_s6_w1 == '0) ? '0 : 3'(WeekDays) - r_s6_w1;
        n_s7_ma = wrap7(4'(r_s6_w1) + 4'(MarLastDoy % WeekDays));
        n_s7_ob = wrap7(4'(r_s6_w1) + 4'(OctLastDoy % WeekDays));
        case (r_rule)
            RuleUs: begin
                n_s7_en = 1'b1;
                n_s7_sd = 9'(n_s7_fs) + 9'(WeekDays);
                n_s7_ed = 9'(NovFirstDoy) + 9'(n_s7_fs);
                n_s7_ss = 17'(UsStartSec);
                n_s7_es = 17'(UsEndSec);
            end
            RuleEu: begin
                n_s7_en = 1'b1;
                n_s7_sd = 9'(MarLastDoy) - 9'(n_s7_ma);
                n_s7_ed = 9'(OctLastDoy) - 9'(n_s7_ob);
                n_s7_ss = 17'(EuSwitchSec);
                n_s7_es = 17'(EuSwitchSec);
            end
            default: begin
                n_s7_en = 1'b0;
                n_s7_sd = '0;
                n_s7_ed = '0;
                n_s7_ss = '0;
                n_s7_es = '0;
            end
        endcase

        n_s8_ge  = (r_s7_doy > r_s7_sd) || ((r_s7_doy == r_s7_sd) && (r_s7_sod >= r_s7_ss));
        n_s8_lt  = (r_s7_doy < r_s7_ed) || ((r_s7_doy == r_s7_ed) && (r_s7_sod < r_s7_es));
        n_s8_dst = r_s7_en && n_s8_ge && n_s8_lt;
        n_s8_sum = 12'(r_base) + (n_s8_dst ? 12'(DstShiftMin) : 12'sd0);
        n_s8_off = (n_s8_sum > 12'(OffsetMax)) ? 11'(OffsetMax) : n_s8_sum[10:0];
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        r_s1_utc  <= i_utc_seconds;
        r_s1_days <= n_s1_prod[50:DayRecipShift];

        r_s2_sod <= 17'(r_s1_utc - n_s2_dsec[31:0]);
        r_s2_mar <= r_s1_days + ((r_s1_days >= 16'(CenturyFixDay)) ?
                                 16'(EpochToMarch + 1) : 16'(EpochToMarch));
        r_s2_wkx <= n_s2_wkx;
        r_s2_wq  <= n_s2_wprod[32:Mod7Shift16];

        r_s3_sod  <= r_s2_sod;
        r_s3_mar  <= r_s2_mar;
        r_s3_cyc  <= n_s3_cprod[32:CycleRecipShft];
        r_s3_wnow <= 3'(r_s2_wkx - 16'(r_s2_wq * 14'(WeekDays)));

        r_s4_sod  <= r_s3_sod;
        r_s4_rem  <= 11'(r_s3_mar - 16'(r_s3_cyc) * 16'(CycleDays));
        r_s4_wnow <= r_s3_wnow;

        r_s5_sod  <= r_s4_sod;
        r_s5_doy  <= n_s5_doy;
        r_s5_wnow <= r_s4_wnow;

        r_s6_sod <= r_s5_sod;
        r_s6_doy <= r_s5_doy;
        r_s6_w1  <= wrap7(4'(r_s5_wnow) + 4'(WeekDays) - 4'(n_s6_dmod));

        r_s7_sod <= r_s6_sod;
        r_s7_doy <= r_s6_doy;
        r_s7_en  <= n_s7_en;
        r_s7_sd  <= n_s7_sd;
        r_s7_ed  <= n_s7_ed;
        r_s7_ss  <= n_s7_ss;
        r_s7_es  <= n_s7_es;

        r_out_off <= n_s8_off;
        r_out_dst <= n_s8_dst;
    end

    assign o_valid          = r_vld[NumStages];
    assign o_offset_minutes = r_out_off;
    assign o_dst_active     = r_out_dst;

    `ASSERT_CLK(a_latency, i_clk, i_rst_n, (start && !busy) |-> ##8 o_valid, "result strobe missing")
    `ASSERT_IMPLY(a_doy_range, i_clk, i_rst_n, r_vld[5], r_s5_doy <= 9'(YearDays), "doy out of range")
    `ASSERT_IMPLY(a_wday_range, i_clk, i_rst_n, r_vld[6], r_s6_w1 < 3'(WeekDays), "weekday out of range")
    `ASSERT_IMPLY(a_std_offset, i_clk, i_rst_n, o_valid && !o_dst_active, o_offset_minutes == r_base, "standard offset mismatch")
    `ASSERT_IMPLY(a_no_rule, i_clk, i_rst_n, o_valid && (r_rule != RuleUs) && (r_rule != RuleEu), !o_dst_active, "dst without rule")

endmodule
